@@ rtl/kpu_pkg.sv @@
// ----------------------------------------------------------------------------
// kpu_pkg
// Shared types, widths and the factorial table for the permutation unranker.
// ----------------------------------------------------------------------------
package kpu_pkg;

    localparam int MAX_ELEMENTS = 12;

    localparam int SIZE_W  = 4;
    localparam int RANK_W  = 29;
    localparam int POS_W   = 4;
    localparam int ELEM_W  = 4;
    localparam int QUO_W   = 4;
    localparam int STEP_W  = 2;
    localparam int DIV_W   = RANK_W + QUO_W - 1;
    localparam int N_CELLS = MAX_ELEMENTS;
    localparam int SLOT_W  = (N_CELLS > 1) ? $clog2(N_CELLS) : 1;

    typedef struct packed {
        logic [SIZE_W-1:0] set_size;
        logic [RANK_W-1:0] rank;
    } request_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element;
        logic              bad_rank;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              init;
        logic              remove;
        logic [SLOT_W-1:0] idx;
    } cell_ctrl_t;

    function automatic logic [RANK_W-1:0] fact(input logic [SIZE_W-1:0] m);
        logic [RANK_W-1:0] f;
        case (m)
            4'd0:    f = 29'd1;
            4'd1:    f = 29'd1;
            4'd2:    f = 29'd2;
            4'd3:    f = 29'd6;
            4'd4:    f = 29'd24;
            4'd5:    f = 29'd120;
            4'd6:    f = 29'd720;
            4'd7:    f = 29'd5040;
            4'd8:    f = 29'd40320;
            4'd9:    f = 29'd362880;
            4'd10:   f = 29'd3628800;
            4'd11:   f = 29'd39916800;
            4'd12:   f = 29'd479001600;
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic rank_invalid(input request_t req);
        return (req.set_size == '0) ||
               (req.set_size > SIZE_W'(MAX_ELEMENTS)) ||
               (req.rank == '0) ||
               (req.rank > fact(req.set_size));
    endfunction

endpackage

@@ rtl/kpu_cell.sv @@
// ----------------------------------------------------------------------------
// kpu_cell
// One slot of the ordered pool of unused values; takes its right neighbour's
// value when a slot at or left of it is removed.
// ----------------------------------------------------------------------------
module kpu_cell (
    input  logic                        clk,
    input  logic [kpu_pkg::SLOT_W-1:0]  slot,
    input  kpu_pkg::cell_ctrl_t         ctrl,
    input  logic [kpu_pkg::ELEM_W-1:0]  right_value,
    output logic [kpu_pkg::ELEM_W-1:0]  value
);
    import kpu_pkg::*;

    logic [ELEM_W-1:0] value_reg;
    logic [ELEM_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.init)
        begin
            value_next = ELEM_W'(slot) + ELEM_W'(1);
        end
        else if (ctrl.remove && (slot >= ctrl.idx))
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ rtl/kpu_divider.sv @@
// ----------------------------------------------------------------------------
// kpu_divider
// Restoring divider, one quotient bit per cycle; the quotient is known to fit
// in QUO_W bits.
// ----------------------------------------------------------------------------
module kpu_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [kpu_pkg::RANK_W-1:0]  dividend,
    input  logic [kpu_pkg::RANK_W-1:0]  divisor,
    output logic                        done,
    output logic [kpu_pkg::QUO_W-1:0]   quotient,
    output logic [kpu_pkg::RANK_W-1:0]  remainder
);
    import kpu_pkg::*;

    logic              busy_reg,    busy_next;
    logic              done_reg,    done_next;
    logic [STEP_W-1:0] step_reg,    step_next;
    logic [RANK_W-1:0] rem_reg,     rem_next;
    logic [RANK_W-1:0] divisor_reg, divisor_next;
    logic [QUO_W-1:0]  quo_reg,     quo_next;

    logic [DIV_W:0]    trial;

    assign trial = {1'b0, DIV_W'(rem_reg)} - {1'b0, DIV_W'(divisor_reg) << step_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = STEP_W'(QUO_W - 1);
            rem_next     = dividend;
            divisor_next = divisor;
            quo_next     = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_next           = trial[RANK_W-1:0];
                quo_next[step_reg] = 1'b1;
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/kth_permutation_unrank_unit.sv @@
// ----------------------------------------------------------------------------
// kth_permutation_unrank_unit
// Factoradic unranking of the k-th permutation of 1..n, one result a position.
// ----------------------------------------------------------------------------
// A valid item holds busy until its last result; a rejected one gives its single
// error result in the next cycle without raising busy.
// Result spacing is set by the 4-step shared divider plus launch and pool update.
// rst_n clears control state asynchronously; pool cells hold no reset value.
module kth_permutation_unrank_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  kpu_pkg::request_t  request,
    output logic               busy,
    output kpu_pkg::result_t   result,
    output logic               result_strobe
);
    import kpu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT
    } state_t;

    state_t            state_reg,  state_next;
    logic [SIZE_W-1:0] n_reg,      n_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [SIZE_W-1:0] count_reg,  count_next;
    logic [RANK_W-1:0] r_reg,      r_next;
    result_t           result_reg, result_next;
    logic              strobe_reg, strobe_next;

    logic              accept;
    logic              bad_in;
    logic [SIZE_W-1:0] left;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic [RANK_W-1:0] div_rem;
    logic [QUO_W-1:0]  q_clamped;
    cell_ctrl_t        cell_ctrl;
    logic [ELEM_W-1:0] pool_value [N_CELLS];

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign bad_in    = rank_invalid(request);
    assign left      = n_reg - SIZE_W'(1) - SIZE_W'(pos_reg);
    assign div_start = (state_reg == ST_LAUNCH);
    assign q_clamped = (div_quo >= QUO_W'(count_reg)) ? QUO_W'(count_reg - SIZE_W'(1))
                                                      : div_quo;

    assign cell_ctrl.init   = accept && !bad_in;
    assign cell_ctrl.remove = (state_reg == ST_WAIT) && div_done;
    assign cell_ctrl.idx    = q_clamped[SLOT_W-1:0];

    kpu_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (r_reg),
        .divisor   (fact(left)),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        logic [ELEM_W-1:0] right_value;
        if (i == N_CELLS - 1)
        begin : g_end
            assign right_value = '0;
        end
        else
        begin : g_mid
            assign right_value = pool_value[i+1];
        end
        kpu_cell u_cell (
            .clk         (clk),
            .slot        (SLOT_W'(i)),
            .ctrl        (cell_ctrl),
            .right_value (right_value),
            .value       (pool_value[i])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        r_next      = r_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (bad_in)
                    begin
                        result_next.position = '0;
                        result_next.element  = '0;
                        result_next.bad_rank = 1'b1;
                        result_next.last     = 1'b1;
                        strobe_next          = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LAUNCH;
                        n_next     = request.set_size;
                        pos_next   = '0;
                        count_next = request.set_size;
                        r_next     = request.rank - RANK_W'(1);
                    end
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    result_next.position = pos_reg;
                    result_next.element  = pool_value[q_clamped[SLOT_W-1:0]];
                    result_next.bad_rank = 1'b0;
                    result_next.last     = (left == '0);
                    strobe_next          = 1'b1;
                    r_next               = div_rem;
                    pos_next             = pos_reg + POS_W'(1);
                    count_next           = count_reg - SIZE_W'(1);
                    state_next           = (left == '0) ? ST_IDLE : ST_LAUNCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        pos_reg    <= pos_next;
        count_reg  <= count_next;
        r_reg      <= r_next;
        result_reg <= result_next;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

@@ rtl/kpu_checker.sv @@
// ----------------------------------------------------------------------------
// kpu_port_checker
// Port-level checks on the permutation unranker, bound to the top level.
// ----------------------------------------------------------------------------
module kpu_port_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  kpu_pkg::request_t  request,
    input  logic               busy,
    input  kpu_pkg::result_t   result,
    input  logic               result_strobe
);
    import kpu_pkg::*;

    // more positions to come: the unit must still be working
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |-> busy)
        else $error("unit idle before final result");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last |-> !busy)
        else $error("unit busy on final result");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.bad_rank |->
            result.last && (result.element == '0) && (result.position == '0))
        else $error("malformed error result");

    a_zero_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((request.rank == '0) || (request.set_size == '0)) |=>
            result_strobe && result.bad_rank)
        else $error("zero rank or size not rejected");

    a_elem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.bad_rank |-> (result.element != '0))
        else $error("zero element in valid result");

endmodule

bind kth_permutation_unrank_unit kpu_port_checker u_kpu_port_checker (.*);
